### hdl/d2q9_pkg.sv
package d2q9_pkg;

    localparam int FRAC_BITS_DEF = 29;
    localparam int NDIR = 9;

    // Direction slots, in stream order
    localparam int DIR_R  = 0;
    localparam int DIR_E  = 1;
    localparam int DIR_N  = 2;
    localparam int DIR_W  = 3;
    localparam int DIR_S  = 4;
    localparam int DIR_NE = 5;
    localparam int DIR_NW = 6;
    localparam int DIR_SW = 7;
    localparam int DIR_SE = 8;

    localparam logic [1:0] WALL_BOTTOM = 2'd1;
    localparam logic [1:0] WALL_TOP    = 2'd2;

    localparam logic CFG_INV_TAU = 1'b0;
    localparam logic CFG_GRAVITY = 1'b1;

    typedef logic signed [31:0] t_s32;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [71:0] t_wide;
    typedef t_s32 [NDIR-1:0] t_dists;

    localparam t_s32 S32_MAX = 32'sh7fff_ffff;
    localparam t_s32 S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_dists f;
        t_s32   r;
        t_s32   vx;
        t_s32   vy;
    } t_mom;

    typedef struct packed {
        t_dists f;
        t_s32   r;
        t_s32   ux;
        t_s32   uy;
    } t_vel;

    typedef struct packed {
        t_dists dists;
        t_s32   density;
        t_s32   vel_x;
        t_s32   vel_y;
    } t_res;

    function automatic t_wide wx(input t_s32 a);
        return t_wide'(a);
    endfunction

    function automatic t_s32 sat32(input t_wide x);
        if (x > t_wide'(S32_MAX)) return S32_MAX;
        if (x < t_wide'(S32_MIN)) return S32_MIN;
        return x[31:0];
    endfunction

    function automatic t_prod mul32(input t_s32 a, input t_s32 b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    // Round half up at bit n, then clamp to 32 bits
    function automatic t_s32 qround(input t_prod p, input int unsigned n);
        t_wide t;
        t = t_wide'(p) + (t_wide'(1) <<< (n - 1));
        return sat32(t >>> n);
    endfunction

endpackage

### hdl/d2q9_bgk_cell_update.sv
// D2Q9 collision for one lattice cell per request.
//
// Input stream: s_axis_tdata carries the nine streamed distributions, rest,
// east, north, west, south, northeast, northwest, southwest, southeast, 32 bits
// each from the low end; s_axis_tuser carries the wall kind (interior, bottom,
// top). Output stream: m_axis_tdata carries the nine new distributions, then
// density, x velocity with half gravity added, and y velocity.
// Config: pulse i_cfg_we with i_cfg_addr 0 for inv_tau, 1 for gravity. Write
// only while no request is in flight.
//
// Throughput is one cell per cycle unless the receiver stalls. The pipeline runs
// through the wall rebuild and moment stages, the radix-2 momentum/density
// divider retiring two quotient bits per stage, and the equilibrium,
// relaxation and force stages.
// Reset empties the pipeline and loads the default inv_tau and gravity.
// A stalled receiver freezes the whole pipeline in place; the result on
// m_axis_tdata holds and s_axis_tready drops until the result is taken.
module d2q9_bgk_cell_update #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,   // dist_rest .. dist_southeast
    input  logic [1:0]   s_axis_tuser,   // wall_kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [383:0] m_axis_tdata,   // out_rest .. out_southeast, density,
                                         // velocity_x, velocity_y
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    logic [30:0]    r_inv_tau;
    d2q9_pkg::t_s32 r_gravity;

    logic           adv;
    logic           wall_valid, div_valid;
    d2q9_pkg::t_mom wall_mom;
    d2q9_pkg::t_vel div_vel;
    d2q9_pkg::t_res res;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_tau <= 31'd894784853;
            r_gravity <= 32'sd537;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                d2q9_pkg::CFG_INV_TAU: r_inv_tau <= i_cfg_wdata[30:0];
                d2q9_pkg::CFG_GRAVITY: r_gravity <= $signed(i_cfg_wdata);
                default:               r_inv_tau <= r_inv_tau;
            endcase
        end
    end

    // Advance every stage unless a finished result is being held
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    d2q9_wall #(.FRAC_BITS(FRAC_BITS)) u_wall (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (s_axis_tvalid),
        .i_dists   (d2q9_pkg::t_dists'(s_axis_tdata)),
        .i_wall    (s_axis_tuser),
        .i_gravity (r_gravity),
        .o_valid   (wall_valid),
        .o_mom     (wall_mom)
    );

    d2q9_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (wall_valid),
        .i_mom   (wall_mom),
        .o_valid (div_valid),
        .o_vel   (div_vel)
    );

    d2q9_coll #(.FRAC_BITS(FRAC_BITS)) u_coll (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (div_valid),
        .i_vel     (div_vel),
        .i_inv_tau (r_inv_tau),
        .i_gravity (r_gravity),
        .o_valid   (m_axis_tvalid),
        .o_res     (res)
    );

    assign m_axis_tdata = {res.vel_y, res.vel_x, res.density, res.dists};

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Zero density gives zero y velocity
    a_zero_rho_vy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.density == '0) |-> (res.vel_y == '0))
        else $error("nonzero y velocity at zero density");

    // Zero density leaves only the half gravity term in x
    a_zero_rho_vx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.density == '0) |->
        (d2q9_pkg::wx(res.vel_x) ==
         ((d2q9_pkg::wx(r_gravity) + d2q9_pkg::t_wide'(1)) >>> 1)))
        else $error("x velocity at zero density is not half gravity");

endmodule

### hdl/d2q9_wall.sv
module d2q9_wall #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  d2q9_pkg::t_dists i_dists,
    input  logic [1:0]       i_wall,
    input  d2q9_pkg::t_s32   i_gravity,
    output logic             o_valid,
    output d2q9_pkg::t_mom   o_mom
);

    typedef struct packed {
        d2q9_pkg::t_dists   f;
        logic [1:0]         wall;
        d2q9_pkg::t_s32     rw;
        logic signed [32:0] hd;
        d2q9_pkg::t_prod    gp;
    } t_ws;

    t_ws            r_a, r_b, r_c, r_d;
    t_ws            n_a, n_b, n_c, n_d;
    d2q9_pkg::t_mom r_e, n_e;
    logic [4:0]     r_v;

    always_comb begin
        d2q9_pkg::t_wide hdw, gr4, acc_r, acc_x, acc_y;

        n_a      = '0;
        n_a.f    = i_dists;
        n_a.wall = i_wall;

        // Wall density and half east-west difference
        n_b = r_a;
        hdw = (d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_E]) - d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_W])
               + d2q9_pkg::t_wide'(1)) >>> 1;
        n_b.hd = hdw[32:0];
        case (r_a.wall)
            d2q9_pkg::WALL_BOTTOM: begin
                n_b.rw = d2q9_pkg::sat32(d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_R])
                    + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_E]) + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_W])
                    + ((d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_S]) + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_SW])
                        + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_SE])) <<< 1));
            end
            d2q9_pkg::WALL_TOP: begin
                n_b.rw = d2q9_pkg::sat32(d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_R])
                    + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_E]) + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_W])
                    + ((d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_N]) + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_NE])
                        + d2q9_pkg::wx(r_a.f[d2q9_pkg::DIR_NW])) <<< 1));
            end
            default: begin
                n_b.rw = '0;
            end
        endcase

        n_c    = r_b;
        n_c.gp = d2q9_pkg::mul32(i_gravity, r_b.rw);

        // Rebuild the three unknown populations at a wall
        n_d = r_c;
        gr4 = (d2q9_pkg::t_wide'(r_c.gp) + (d2q9_pkg::t_wide'(1) <<< (FRAC_BITS + 1)))
              >>> (FRAC_BITS + 2);
        hdw = d2q9_pkg::t_wide'(r_c.hd);
        case (r_c.wall)
            d2q9_pkg::WALL_BOTTOM: begin
                n_d.f[d2q9_pkg::DIR_N]  = r_c.f[d2q9_pkg::DIR_S];
                n_d.f[d2q9_pkg::DIR_NE] = d2q9_pkg::sat32(
                    d2q9_pkg::wx(r_c.f[d2q9_pkg::DIR_SW]) - hdw - gr4);
                n_d.f[d2q9_pkg::DIR_NW] = d2q9_pkg::sat32(
                    d2q9_pkg::wx(r_c.f[d2q9_pkg::DIR_SE]) + hdw + gr4);
            end
            d2q9_pkg::WALL_TOP: begin
                n_d.f[d2q9_pkg::DIR_S]  = r_c.f[d2q9_pkg::DIR_N];
                n_d.f[d2q9_pkg::DIR_SW] = d2q9_pkg::sat32(
                    d2q9_pkg::wx(r_c.f[d2q9_pkg::DIR_NE]) + hdw + gr4);
                n_d.f[d2q9_pkg::DIR_SE] = d2q9_pkg::sat32(
                    d2q9_pkg::wx(r_c.f[d2q9_pkg::DIR_NW]) - hdw - gr4);
            end
            default: begin
                n_d.f = r_c.f;
            end
        endcase

        // Moments
        acc_r = '0;
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            acc_r = acc_r + d2q9_pkg::wx(r_d.f[q]);
        end
        acc_x = d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_E]) - d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_W])
              + d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_NE]) - d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_NW])
              - d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_SW]) + d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_SE]);
        acc_y = d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_N]) - d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_S])
              + d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_NE]) + d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_NW])
              - d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_SW]) - d2q9_pkg::wx(r_d.f[d2q9_pkg::DIR_SE]);
        n_e.f  = r_d.f;
        n_e.r  = d2q9_pkg::sat32(acc_r);
        n_e.vx = d2q9_pkg::sat32(acc_x);
        n_e.vy = d2q9_pkg::sat32(acc_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
        end
    end

    assign o_valid = r_v[4];
    assign o_mom   = r_e;

endmodule

### hdl/d2q9_div.sv
module d2q9_div #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  d2q9_pkg::t_mom i_mom,
    output logic           o_valid,
    output d2q9_pkg::t_vel o_vel
);

    localparam int DW  = 32 + FRAC_BITS;
    localparam int NST = (DW + 1) / 2;

    // Two lanes: x and y momentum over the same density
    typedef struct packed {
        logic [1:0][31:0] un;
        logic [1:0][31:0] rem;
        logic [1:0][31:0] q;
        logic [1:0]       ovf;
        logic [1:0]       neg;
        logic [31:0]      ud;
        d2q9_pkg::t_dists f;
        d2q9_pkg::t_s32   r;
    } t_dst;

    t_dst [NST:0]   r_st, n_st;
    d2q9_pkg::t_vel r_o, n_o;
    logic [NST+1:0] r_v;

    always_comb begin
        logic [32:0]    sh;
        logic           qb;
        d2q9_pkg::t_s32 num;
        d2q9_pkg::t_s32 res [2];

        n_st[0]    = '0;
        n_st[0].f  = i_mom.f;
        n_st[0].r  = i_mom.r;
        n_st[0].ud = i_mom.r[31] ? (~i_mom.r + 32'd1) : i_mom.r;
        for (int l = 0; l < 2; l++) begin
            num = (l == 0) ? i_mom.vx : i_mom.vy;
            n_st[0].un[l]  = num[31] ? (~num + 32'd1) : num;
            n_st[0].neg[l] = num[31] ^ i_mom.r[31];
        end

        // Restoring division, two quotient bits per stage
        for (int s = 0; s < NST; s++) begin
            n_st[s+1] = r_st[s];
            for (int k = 0; k < 2; k++) begin
                if (s * 2 + k < DW) begin
                    for (int l = 0; l < 2; l++) begin
                        sh = {n_st[s+1].rem[l], n_st[s+1].un[l][31]};
                        n_st[s+1].un[l] = {n_st[s+1].un[l][30:0], 1'b0};
                        if (sh >= {1'b0, n_st[s+1].ud}) begin
                            sh = sh - {1'b0, n_st[s+1].ud};
                            qb = 1'b1;
                        end else begin
                            qb = 1'b0;
                        end
                        n_st[s+1].rem[l] = sh[31:0];
                        n_st[s+1].ovf[l] = n_st[s+1].ovf[l] | n_st[s+1].q[l][31];
                        n_st[s+1].q[l]   = {n_st[s+1].q[l][30:0], qb};
                    end
                end
            end
        end

        // Apply sign and clamp; a zero density gives zero
        for (int l = 0; l < 2; l++) begin
            if (r_st[NST].ud == '0) begin
                res[l] = '0;
            end else if (r_st[NST].ovf[l] || r_st[NST].q[l][31]) begin
                res[l] = r_st[NST].neg[l] ? d2q9_pkg::S32_MIN : d2q9_pkg::S32_MAX;
            end else if (r_st[NST].neg[l]) begin
                res[l] = -$signed(r_st[NST].q[l]);
            end else begin
                res[l] = $signed(r_st[NST].q[l]);
            end
        end
        n_o.f  = r_st[NST].f;
        n_o.r  = r_st[NST].r;
        n_o.ux = res[0];
        n_o.uy = res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
            r_o  <= n_o;
        end
    end

    assign o_valid = r_v[NST+1];
    assign o_vel   = r_o;

endmodule

### hdl/d2q9_coll.sv
module d2q9_coll #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  d2q9_pkg::t_vel i_vel,
    input  logic [30:0]    i_inv_tau,
    input  d2q9_pkg::t_s32 i_gravity,
    output logic           o_valid,
    output d2q9_pkg::t_res o_res
);

    localparam int NS = 8;
    localparam logic [63:0] QMAX = 64'd2147483647;

    localparam logic [63:0] W49_RAW  = ((64'd4 << (FRAC_BITS + 1)) + 64'd9) / 64'd18;
    localparam logic [63:0] W19_RAW  = ((64'd1 << (FRAC_BITS + 1)) + 64'd9) / 64'd18;
    localparam logic [63:0] W136_RAW = ((64'd1 << (FRAC_BITS + 1)) + 64'd36) / 64'd72;
    localparam logic [63:0] C13_RAW  = ((64'd1 << (FRAC_BITS + 1)) + 64'd3) / 64'd6;
    localparam logic [63:0] C112_RAW = ((64'd1 << (FRAC_BITS + 1)) + 64'd12) / 64'd24;
    localparam logic [63:0] ONE_RAW  = 64'd1 << FRAC_BITS;

    localparam d2q9_pkg::t_s32 W49  = (W49_RAW > QMAX) ? d2q9_pkg::S32_MAX : 32'(W49_RAW);
    localparam d2q9_pkg::t_s32 W19  = (W19_RAW > QMAX) ? d2q9_pkg::S32_MAX : 32'(W19_RAW);
    localparam d2q9_pkg::t_s32 W136 = (W136_RAW > QMAX) ? d2q9_pkg::S32_MAX : 32'(W136_RAW);
    localparam d2q9_pkg::t_s32 C13  = (C13_RAW > QMAX) ? d2q9_pkg::S32_MAX : 32'(C13_RAW);
    localparam d2q9_pkg::t_s32 C112 = (C112_RAW > QMAX) ? d2q9_pkg::S32_MAX : 32'(C112_RAW);
    localparam d2q9_pkg::t_s32 ONE  = (ONE_RAW > QMAX) ? d2q9_pkg::S32_MAX : 32'(ONE_RAW);

    typedef struct packed {
        d2q9_pkg::t_dists          f;
        d2q9_pkg::t_s32            r;
        d2q9_pkg::t_s32            ux;
        d2q9_pkg::t_s32            uy;
        d2q9_pkg::t_s32            velx;
        d2q9_pkg::t_dists          cu;
        d2q9_pkg::t_dists          cu2;
        d2q9_pkg::t_dists          poly;
        d2q9_pkg::t_dists          diff;
        d2q9_pkg::t_prod [2:0]     pw;
        d2q9_pkg::t_s32  [2:0]     wr;
        d2q9_pkg::t_prod           prg;
        d2q9_pkg::t_s32            rg;
        d2q9_pkg::t_prod [1:0]     pf;
        d2q9_pkg::t_s32            fa;
        d2q9_pkg::t_s32            fd;
        d2q9_pkg::t_prod [8:0]     pq;
    } t_cs;

    t_cs         r_s [1:NS];
    t_cs         n_s [1:NS];
    logic [NS:1] r_v;

    function automatic int wsel(input int q);
        if (q == d2q9_pkg::DIR_R) return 0;
        if (q <= d2q9_pkg::DIR_S) return 1;
        return 2;
    endfunction

    always_comb begin
        d2q9_pkg::t_s32  usq;
        d2q9_pkg::t_wide frc;

        // Velocity projections, weighted density, density times gravity
        n_s[1]      = '0;
        n_s[1].f    = i_vel.f;
        n_s[1].r    = i_vel.r;
        n_s[1].ux   = i_vel.ux;
        n_s[1].uy   = i_vel.uy;
        n_s[1].velx = d2q9_pkg::sat32(d2q9_pkg::wx(i_vel.ux)
                      + ((d2q9_pkg::wx(i_gravity) + d2q9_pkg::t_wide'(1)) >>> 1));
        n_s[1].cu[d2q9_pkg::DIR_E]  = i_vel.ux;
        n_s[1].cu[d2q9_pkg::DIR_N]  = i_vel.uy;
        n_s[1].cu[d2q9_pkg::DIR_W]  = d2q9_pkg::sat32(-d2q9_pkg::wx(i_vel.ux));
        n_s[1].cu[d2q9_pkg::DIR_S]  = d2q9_pkg::sat32(-d2q9_pkg::wx(i_vel.uy));
        n_s[1].cu[d2q9_pkg::DIR_NE] = d2q9_pkg::sat32(d2q9_pkg::wx(i_vel.ux)
                                      + d2q9_pkg::wx(i_vel.uy));
        n_s[1].cu[d2q9_pkg::DIR_NW] = d2q9_pkg::sat32(d2q9_pkg::wx(i_vel.uy)
                                      - d2q9_pkg::wx(i_vel.ux));
        n_s[1].cu[d2q9_pkg::DIR_SW] = d2q9_pkg::sat32(-d2q9_pkg::wx(i_vel.ux)
                                      - d2q9_pkg::wx(i_vel.uy));
        n_s[1].cu[d2q9_pkg::DIR_SE] = d2q9_pkg::sat32(d2q9_pkg::wx(i_vel.ux)
                                      - d2q9_pkg::wx(i_vel.uy));
        n_s[1].pw[0] = d2q9_pkg::mul32(W49, i_vel.r);
        n_s[1].pw[1] = d2q9_pkg::mul32(W19, i_vel.r);
        n_s[1].pw[2] = d2q9_pkg::mul32(W136, i_vel.r);
        n_s[1].prg   = d2q9_pkg::mul32(i_vel.r, i_gravity);

        // Square the projections
        n_s[2] = r_s[1];
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            n_s[2].pq[q] = d2q9_pkg::mul32(r_s[1].cu[q], r_s[1].cu[q]);
        end
        for (int k = 0; k < 3; k++) begin
            n_s[2].wr[k] = d2q9_pkg::qround(r_s[1].pw[k], FRAC_BITS);
        end
        n_s[2].rg = d2q9_pkg::qround(r_s[1].prg, FRAC_BITS);

        n_s[3] = r_s[2];
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            n_s[3].cu2[q] = d2q9_pkg::qround(r_s[2].pq[q], FRAC_BITS);
        end
        n_s[3].pf[0] = d2q9_pkg::mul32(r_s[2].rg, C13);
        n_s[3].pf[1] = d2q9_pkg::mul32(r_s[2].rg, C112);

        // Equilibrium polynomial per direction
        n_s[4] = r_s[3];
        usq = d2q9_pkg::sat32(d2q9_pkg::wx(r_s[3].cu2[d2q9_pkg::DIR_E])
                              + d2q9_pkg::wx(r_s[3].cu2[d2q9_pkg::DIR_N]));
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            n_s[4].poly[q] = d2q9_pkg::sat32(d2q9_pkg::wx(ONE)
                + d2q9_pkg::t_wide'(3) * d2q9_pkg::wx(r_s[3].cu[q])
                + ((d2q9_pkg::t_wide'(9) * d2q9_pkg::wx(r_s[3].cu2[q])
                    + d2q9_pkg::t_wide'(1)) >>> 1)
                - ((d2q9_pkg::t_wide'(3) * d2q9_pkg::wx(usq) + d2q9_pkg::t_wide'(1)) >>> 1));
        end
        n_s[4].fa = d2q9_pkg::qround(r_s[3].pf[0], FRAC_BITS);
        n_s[4].fd = d2q9_pkg::qround(r_s[3].pf[1], FRAC_BITS);

        n_s[5] = r_s[4];
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            n_s[5].pq[q] = d2q9_pkg::mul32(r_s[4].wr[wsel(q)], r_s[4].poly[q]);
        end

        n_s[6] = r_s[5];
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            n_s[6].diff[q] = d2q9_pkg::sat32(d2q9_pkg::wx(r_s[5].f[q])
                - d2q9_pkg::wx(d2q9_pkg::qround(r_s[5].pq[q], FRAC_BITS)));
        end

        n_s[7] = r_s[6];
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            n_s[7].pq[q] = d2q9_pkg::mul32($signed({1'b0, i_inv_tau}), r_s[6].diff[q]);
        end

        // Relax and add the body force
        n_s[8] = r_s[7];
        for (int q = 0; q < d2q9_pkg::NDIR; q++) begin
            case (q)
                d2q9_pkg::DIR_E:  frc = d2q9_pkg::wx(r_s[7].fa);
                d2q9_pkg::DIR_W:  frc = -d2q9_pkg::wx(r_s[7].fa);
                d2q9_pkg::DIR_NE: frc = d2q9_pkg::wx(r_s[7].fd);
                d2q9_pkg::DIR_SE: frc = d2q9_pkg::wx(r_s[7].fd);
                d2q9_pkg::DIR_NW: frc = -d2q9_pkg::wx(r_s[7].fd);
                d2q9_pkg::DIR_SW: frc = -d2q9_pkg::wx(r_s[7].fd);
                default:          frc = '0;
            endcase
            n_s[8].f[q] = d2q9_pkg::sat32(d2q9_pkg::wx(r_s[7].f[q])
                - d2q9_pkg::wx(d2q9_pkg::qround(r_s[7].pq[q], FRAC_BITS)) + frc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_valid       = r_v[NS];
    assign o_res.dists   = r_s[NS].f;
    assign o_res.density = r_s[NS].r;
    assign o_res.vel_x   = r_s[NS].velx;
    assign o_res.vel_y   = r_s[NS].uy;

endmodule
